### src/ugrf_pkg.sv
// ----------------------------------------------------------------------------
// ugrf_pkg
// shared word types and sizes for the utf-8 glyph range filter
// ----------------------------------------------------------------------------
package ugrf_pkg;

    // most result words that one input word can cause
    localparam int MaxResults = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       string_end;
    } out_word_t;

    // results of one input word, handed from the decoder to the output stage
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [2:0]                 count;
        logic                       present;
        logic                       ends;
    } group_t;

endpackage

### src/ugrf_decode.sv
// ----------------------------------------------------------------------------
// ugrf_decode
// sequence state and single-pass decode of one input word into a result group
// ----------------------------------------------------------------------------
module ugrf_decode
    import ugrf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_word_t item,
    input  logic     take,
    output group_t   grp
);

    localparam logic [7:0]  LeadMask2 = 8'hE0;
    localparam logic [7:0]  Lead2     = 8'hC0;
    localparam logic [7:0]  LeadMask3 = 8'hF0;
    localparam logic [7:0]  Lead3     = 8'hE0;
    localparam logic [7:0]  LeadMask4 = 8'hF8;
    localparam logic [7:0]  Lead4     = 8'hF0;
    localparam logic [20:0] LatinLo   = 21'h00020;
    localparam logic [20:0] LatinHi   = 21'h000FF;
    localparam logic [20:0] PunctLo   = 21'h02013;
    localparam logic [20:0] PunctHi   = 21'h02026;
    localparam logic [20:0] QuoteLo   = 21'h02018;
    localparam logic [20:0] QuoteHi   = 21'h0201F;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        if (!c[7]) return 3'd1;
        if ((c & LeadMask2) == Lead2) return 3'd2;
        if ((c & LeadMask3) == Lead3) return 3'd3;
        if ((c & LeadMask4) == Lead4) return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic glyph_kept(input logic [3:0][7:0] s, input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd1:    cp = {13'd0, s[0]};
            3'd2:    cp = {10'd0, s[0][4:0], s[1][5:0]};
            3'd3:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        endcase
        return (cp >= LatinLo && cp <= LatinHi) || (cp >= PunctLo && cp <= PunctHi)
            || (cp >= QuoteLo && cp <= QuoteHi);
    endfunction

    logic [2:0][7:0] seq_buffer_reg, seq_buffer_next;
    logic [1:0]      bytes_held_reg, bytes_held_next;
    logic [2:0]      bytes_needed_reg, bytes_needed_next;

    logic [3:0][7:0] run;
    logic [3:0][7:0] s;
    logic [3:0][7:0] res;
    logic [2:0]      n;
    logic [2:0]      pos;
    logic [2:0]      len;
    logic [2:0]      k;
    logic [2:0]      need_dec;

    always_comb
    begin
        run = {item.in_byte, seq_buffer_reg};
        run[bytes_held_reg] = item.in_byte;
        n = {1'b0, bytes_held_reg} + 3'd1;
        s = run;
        res = '0;
        k = 3'd0;
        pos = 3'd0;
        len = 3'd0;
        need_dec = bytes_needed_reg - 3'd1;
        seq_buffer_next = seq_buffer_reg;
        bytes_held_next = bytes_held_reg;
        bytes_needed_next = bytes_needed_reg;

        if (item.string_last)
        begin
            // flush: walk the run, leads that cannot finish are skipped
            for (int step = 0; step < 4; step++)
            begin
                if (pos < n)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        s[j] = run[2'(pos + 3'(j))];
                    end
                    len = lead_length(s[0]);
                    if (len == 3'd0 || (pos + len) > n)
                    begin
                        pos = pos + 3'd1;
                    end
                    else
                    begin
                        if (glyph_kept(s, len))
                        begin
                            for (int j = 0; j < 4; j++)
                            begin
                                if (3'(j) < len && k < 3'(MaxResults))
                                begin
                                    res[k[1:0]] = s[j];
                                    k = k + 3'd1;
                                end
                            end
                        end
                        pos = pos + len;
                    end
                end
            end
            bytes_held_next = 2'd0;
            bytes_needed_next = 3'd0;
        end
        else if (bytes_held_reg == 2'd0)
        begin
            len = lead_length(item.in_byte);
            if (len == 3'd1)
            begin
                if (glyph_kept(run, 3'd1))
                begin
                    res[0] = item.in_byte;
                    k = 3'd1;
                end
            end
            else if (len != 3'd0)
            begin
                seq_buffer_next[0] = item.in_byte;
                bytes_held_next = 2'd1;
                bytes_needed_next = len - 3'd1;
            end
        end
        else
        begin
            bytes_needed_next = need_dec;
            if (need_dec == 3'd0)
            begin
                if (glyph_kept(run, n))
                begin
                    res = run;
                    k = n;
                end
                bytes_held_next = 2'd0;
            end
            else if (bytes_held_reg < 2'd3)
            begin
                seq_buffer_next[bytes_held_reg] = item.in_byte;
                bytes_held_next = bytes_held_reg + 2'd1;
            end
        end

        grp.bytes = res;
        grp.ends = item.string_last;
        // a string end with nothing kept becomes one bare marker
        grp.present = !(item.string_last && k == 3'd0);
        grp.count = (item.string_last && k == 3'd0) ? 3'd1 : k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_held_reg <= 2'd0;
            bytes_needed_reg <= 3'd0;
        end
        else if (take)
        begin
            bytes_held_reg <= bytes_held_next;
            bytes_needed_reg <= bytes_needed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_buffer_reg <= seq_buffer_next;
        end
    end

`ifndef SYNTHESIS
    // a partial sequence always waits for at least one more byte
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_held_reg != 2'd0 |-> bytes_needed_reg != 3'd0)
        else $error("partial sequence with nothing needed");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && item.string_last |=> bytes_held_reg == 2'd0 && bytes_needed_reg == 3'd0)
        else $error("sequence state survived a string end");
`endif

endmodule

### src/ugrf_serial.sv
// ----------------------------------------------------------------------------
// ugrf_serial
// result group register, sends it out one word per cycle unless out_stall
// ----------------------------------------------------------------------------
module ugrf_serial
    import ugrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  group_t    grp,
    input  logic      load,
    output logic      free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic [MaxResults-1:0][7:0] byte_reg, byte_next;
    logic [2:0]                 count_reg, count_next;
    logic                       present_reg, present_next;
    logic                       end_reg, end_next;
    logic                       pop;

    assign out_valid = count_reg != 3'd0;
    assign pop = out_valid && !out_stall;
    // free when empty or when the last word leaves this cycle
    assign free = count_reg == 3'd0 || (count_reg == 3'd1 && pop);

    assign out_data.out_byte = byte_reg[0];
    assign out_data.byte_present = present_reg;
    assign out_data.string_end = end_reg && count_reg == 3'd1;

    always_comb
    begin
        byte_next = byte_reg;
        count_next = count_reg;
        present_next = present_reg;
        end_next = end_reg;
        if (load && grp.count != 3'd0)
        begin
            byte_next = grp.bytes;
            count_next = grp.count;
            present_next = grp.present;
            end_next = grp.ends;
        end
        else if (pop)
        begin
            byte_next = {8'h00, byte_reg[MaxResults-1:1]};
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        present_reg <= present_next;
        end_reg <= end_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(MaxResults))
        else $error("result group count overflow");

    // a new group may only land on an empty or draining register
    assert property (@(posedge clk) disable iff (!rst_n)
        load && grp.count != 3'd0 |-> free)
        else $error("result group overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_present |-> out_data.string_end)
        else $error("bare marker without string end");
`endif

endmodule

### src/utf8_glyph_range_filter.sv
// ----------------------------------------------------------------------------
// utf8_glyph_range_filter
// utf-8 byte stream filter that keeps only code points in the glyph ranges
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid, in_stall, in_data): one text byte per word,
//   string_last marks the final byte of a string
// - output channel (out_valid, out_stall, out_data): bytes of kept sequences,
//   unchanged and in order; every string end gives one word with string_end
//   set, a bare marker (byte_present low) if nothing of that tail was kept
// - words pass the input register, the decoder, then the result register
// - throughput: one input word per cycle unless in_stall; a word completing a
//   kept sequence holds the result register until the group drains, one word
//   per cycle unless out_stall, and a later word with results waits meanwhile
// - reset clears the partial sequence and empties both registers
// - out_stall holds the current output word; the input register keeps its
//   word and in_stall rises once the result register cannot take it
// ----------------------------------------------------------------------------
module utf8_glyph_range_filter
    import ugrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic     in_valid_reg, in_valid_next;
    in_word_t in_data_reg;
    group_t   grp;
    logic     free;
    logic     take;
    logic     accept;

    // words with no results only touch the sequence state
    assign take = in_valid_reg && (grp.count == 3'd0 || free);
    assign in_stall = in_valid_reg && !take;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
    end

    ugrf_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_data_reg),
        .take  (take),
        .grp   (grp)
    );

    ugrf_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .load      (take),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### dv/utf8_glyph_range_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_glyph_range_filter_tb
// self-checking bench for the utf-8 glyph range filter
// ----------------------------------------------------------------------------
// a table of hand-picked byte strings runs first; a few rows carry their
// expected word, the rest are predicted. random strings follow, mostly
// well-formed sequences with random content, plus noise and cut-off tails.
// both sides idle in random bursts; every output word is compared in order
// ----------------------------------------------------------------------------
module utf8_glyph_range_filter_tb;
    import ugrf_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        out_word_t  want;
    } dir_row_t;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } text_row_t;

    localparam int DirCount = 24;
    localparam int QuietLimit = 2000;

    // typed rows: plain ascii, control char, invalid lead, stray continuation
    localparam dir_row_t DirRows [DirCount] = '{
        '{8'h41, 1'b1, 1'b1, {8'h41, 1'b1, 1'b1}},
        '{8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1}},
        '{8'h80, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1}},
        '{8'h7F, 1'b0, 1'b0, 10'h000},
        '{8'h1F, 1'b0, 1'b0, 10'h000},
        '{8'hC3, 1'b0, 1'b0, 10'h000},
        '{8'hA9, 1'b0, 1'b0, 10'h000},
        '{8'hE2, 1'b0, 1'b0, 10'h000},
        '{8'h80, 1'b0, 1'b0, 10'h000},
        '{8'h93, 1'b0, 1'b0, 10'h000},
        '{8'hE2, 1'b0, 1'b0, 10'h000},
        '{8'h80, 1'b0, 1'b0, 10'h000},
        '{8'hA6, 1'b0, 1'b0, 10'h000},
        '{8'hC0, 1'b0, 1'b0, 10'h000},
        '{8'h80, 1'b0, 1'b0, 10'h000},
        '{8'hF0, 1'b0, 1'b0, 10'h000},
        '{8'h80, 1'b0, 1'b0, 10'h000},
        '{8'h80, 1'b0, 1'b0, 10'h000},
        '{8'hA0, 1'b1, 1'b0, 10'h000},
        '{8'hE2, 1'b0, 1'b0, 10'h000},
        '{8'h41, 1'b1, 1'b0, 10'h000},
        '{8'hC1, 1'b0, 1'b0, 10'h000},
        '{8'h81, 1'b1, 1'b0, 10'h000}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;

    text_row_t text_q [$];
    out_word_t kept_q [$];
    text_row_t cur_row;
    int        total_words;
    int        sent = 0;
    int        fails = 0;
    int        in_gap = 0;
    int        stall_left = 0;
    int        quiet = 0;

    // partial sequence held by the decoder
    logic [7:0] pend_buf [3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0] pend_held = 2'd0;
    logic [2:0] pend_need = 3'd0;

    utf8_glyph_range_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int seq_len(logic [7:0] b);
        if (b < 8'h80) return 1;
        if ((b & 8'hE0) == 8'hC0) return 2;
        if ((b & 8'hF0) == 8'hE0) return 3;
        if ((b & 8'hF8) == 8'hF0) return 4;
        return 0;
    endfunction

    function automatic bit glyph_ok(logic [20:0] cp);
        return (cp >= 21'h20 && cp <= 21'hFF) || (cp >= 21'h2013 && cp <= 21'h2026)
            || (cp >= 21'h2018 && cp <= 21'h201F);
    endfunction

    function automatic logic [20:0] decode_cp(logic [7:0] s [4], int at, int len);
        logic [20:0] cp;
        case (len)
            1: cp = {13'b0, s[at]};
            2: cp = {10'b0, s[at][4:0], s[at+1][5:0]};
            3: cp = {5'b0, s[at][3:0], s[at+1][5:0], s[at+2][5:0]};
            default: cp = {s[at][2:0], s[at+1][5:0], s[at+2][5:0], s[at+3][5:0]};
        endcase
        return cp;
    endfunction

    function automatic void keep_seq(logic [7:0] s [4], int at, int len,
                                     ref out_word_t grp [$]);
        out_word_t m;
        if (!glyph_ok(decode_cp(s, at, len))) return;
        for (int j = 0; j < len && grp.size() < MaxResults; j++) begin
            m.out_byte = s[at+j];
            m.byte_present = 1'b1;
            m.string_end = 1'b0;
            grp = {grp, m};
        end
    endfunction

    // words the filter owes for one accepted input word
    function automatic void predict_word(in_word_t w, ref out_word_t grp [$]);
        logic [7:0] run [4];
        out_word_t  m;
        int         n;
        int         i;
        int         len;
        grp = {};
        for (i = 0; i < 3; i++) run[i] = pend_buf[i];
        run[3] = 8'h00;
        n = pend_held;
        run[n] = w.in_byte;
        n++;
        if (w.string_last) begin
            // unfinished leads are dropped, the rest is rescanned as new leads
            i = 0;
            while (i < n) begin
                len = seq_len(run[i]);
                if (len == 0 || i + len > n) i++;
                else begin
                    keep_seq(run, i, len, grp);
                    i += len;
                end
            end
            pend_held = 2'd0;
            pend_need = 3'd0;
            if (grp.size() == 0) begin
                m = '0;
                m.string_end = 1'b1;
            end else begin
                m = grp.pop_back();
                m.string_end = 1'b1;
            end
            grp = {grp, m};
            return;
        end
        if (pend_held == 2'd0) begin
            len = seq_len(w.in_byte);
            if (len == 1) keep_seq(run, 0, 1, grp);
            else if (len > 1) begin
                pend_buf[0] = w.in_byte;
                pend_held = 2'd1;
                pend_need = 3'(len - 1);
            end
            return;
        end
        pend_need = pend_need - 3'd1;
        if (pend_need == 3'd0) begin
            keep_seq(run, 0, n, grp);
            pend_held = 2'd0;
        end else if (pend_held < 2'd3) begin
            pend_buf[pend_held] = w.in_byte;
            pend_held = pend_held + 2'd1;
        end
    endfunction

    function automatic bit quiet_run();
        return (sent + 40 >= total_words) || ((sent / 50) % 4 == 3);
    endfunction

    task automatic report(string what, int got, int want);
        if (fails < 40)
            $display("error: %s got %0h want %0h after %0d words", what, got, want, sent);
        fails++;
    endtask

    task automatic check_word(out_word_t got);
        out_word_t want;
        if (kept_q.size() == 0) begin
            report("unexpected word", got, 0);
            return;
        end
        want = kept_q.pop_front();
        if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
        if (got.byte_present !== want.byte_present)
            report("byte_present", got.byte_present, want.byte_present);
        if (got.string_end !== want.string_end)
            report("string_end", got.string_end, want.string_end);
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_random_strings(int target);
        logic [7:0] ch [4];
        text_row_t  r;
        int         len;
        int         nchars;
        int         keep;
        while (text_q.size() < target) begin
            nchars = $urandom_range(1, 6);
            for (int c = 0; c < nchars; c++) begin
                case ($urandom_range(0, 9)) inside
                    0, 9: begin ch[0] = 8'($urandom_range(8'h20, 8'h7E)); len = 1; end
                    1: begin ch[0] = 8'($urandom_range(0, 8'h7F)); len = 1; end
                    2: begin
                        ch[0] = 8'hC0 | 8'($urandom_range(0, 31));
                        ch[1] = cont_byte();
                        len = 2;
                    end
                    3: begin
                        // typographic punctuation block
                        ch[0] = 8'hE2;
                        ch[1] = 8'h80;
                        ch[2] = 8'($urandom_range(8'h90, 8'hA7));
                        len = 3;
                    end
                    4: begin
                        ch[0] = 8'hE0 | 8'($urandom_range(0, 15));
                        ch[1] = cont_byte();
                        ch[2] = cont_byte();
                        len = 3;
                    end
                    5: begin
                        ch[0] = 8'hF0 | 8'($urandom_range(0, 7));
                        ch[1] = cont_byte();
                        ch[2] = cont_byte();
                        ch[3] = cont_byte();
                        len = 4;
                    end
                    6: begin
                        ch[0] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                     : 8'($urandom_range(8'hF8, 8'hFF));
                        len = 1;
                    end
                    7: begin ch[0] = 8'($urandom); len = 1; end
                    default: begin
                        ch[0] = 8'($urandom_range(8'hC2, 8'hC3));
                        ch[1] = 8'($urandom_range(8'h80, 8'hBF));
                        len = 2;
                    end
                endcase
                keep = len;
                // cut sequences, mostly at the string tail
                if (len > 1 && (c == nchars - 1 ? $urandom_range(0, 3) == 0
                                                : $urandom_range(0, 11) == 0))
                    keep = $urandom_range(1, len - 1);
                for (int j = 0; j < keep; j++) begin
                    r.w.in_byte = ch[j];
                    r.w.string_last = (c == nchars - 1) && (j == keep - 1);
                    r.typed = 1'b0;
                    r.want = '0;
                    text_q = {text_q, r};
                end
            end
        end
    endtask

    initial begin
        text_row_t r;
        for (int i = 0; i < DirCount; i++) begin
            r.w.in_byte = DirRows[i].b;
            r.w.string_last = DirRows[i].last;
            r.typed = DirRows[i].typed;
            r.want = DirRows[i].want;
            text_q = {text_q, r};
        end
        add_random_strings(280);
        total_words = text_q.size();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (text_q.size() != 0 || in_valid || kept_q.size() != 0) @(negedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("utf8_glyph_range_filter regression: pass");
        else
            $display("utf8_glyph_range_filter regression: fail");
        $finish;
    end

    // output check, prediction and input drive share one process
    always @(posedge clk) begin : drive
        bit        took;
        out_word_t grp [$];
        if (rst_n) begin
            took = 1'b0;
            if (out_valid && !out_stall) check_word(out_data);
            if (in_valid && !in_stall) begin
                predict_word(cur_row.w, grp);
                if (cur_row.typed) kept_q = {kept_q, cur_row.want};
                else kept_q = {kept_q, grp};
                sent++;
                took = 1'b1;
            end
            if (!in_valid || took) begin
                if (in_gap != 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (text_q.size() == 0 ||
                             ((sent == DirCount || sent == DirCount + 130) &&
                              kept_q.size() != 0)) begin
                    // after the table and once mid-run, let the filter drain
                    in_valid <= 1'b0;
                end else begin
                    cur_row = text_q.pop_front();
                    in_valid <= 1'b1;
                    in_data <= cur_row.w;
                    if (!quiet_run() && $urandom_range(0, 5) == 0)
                        in_gap = $urandom_range(1, 17);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (stall_left != 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet_run() && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
            else if (quiet + 1 >= QuietLimit) begin
                $display("utf8_glyph_range_filter regression: fail");
                $finish;
            end else quiet <= quiet + 1;
        end
    end

endmodule

### sim.f
src/ugrf_pkg.sv
src/ugrf_decode.sv
src/ugrf_serial.sv
src/utf8_glyph_range_filter.sv
dv/utf8_glyph_range_filter_tb.sv
